>>> hdl/i2cm_pkg.sv
// Package: phase codes, actions, status codes and defaults for the I2C master engine.
package i2cm_pkg;

    localparam int COUNT_WIDTH_DEFAULT = 16;
    localparam logic [15:0] DEFAULT_HALF = 16'd5;
    localparam logic [7:0] DEFAULT_RECOVERY = 8'd9;

    typedef enum logic [4:0] {
        PH_IDLE, PH_PROBE, PH_RLO, PH_RHI,
        PH_RSTOP_A, PH_RSTOP_B, PH_RSTOP_C,
        PH_START_A, PH_START_B, PH_START_C,
        PH_WBIT_A, PH_WBIT_B, PH_WBIT_C,
        PH_WACK_A, PH_WACK_B, PH_WACK_C,
        PH_RBIT_A, PH_RBIT_B, PH_RBIT_C,
        PH_RACK_A, PH_RACK_B, PH_RACK_C,
        PH_FSTOP_A, PH_FSTOP_B, PH_FSTOP_C,
        PH_WAIT_BYTE
    } phase_t;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_BEGIN = 2'd1,
        ACT_WBYTE = 2'd2,
        ACT_NOP   = 2'd3
    } action_t;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NACK    = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;
    localparam logic [1:0] ST_REFUSED = 2'd3;

    localparam logic [0:0] CFG_HALF     = 1'b0;
    localparam logic [0:0] CFG_RECOVERY = 1'b1;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       read_last;
        logic       need_byte;
        logic       busy_res;
        logic       done_res;
        logic [1:0] status;
    } result_t;

endpackage

>>> hdl/i2cm_core.sv
// Core: engine state machine; one input transaction per cycle while step is high, one result per transaction.
module i2cm_core #(
    parameter int COUNT_WIDTH = i2cm_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic [1:0]             action,
    input  logic                   sda_in,
    input  logic                   scl_in,
    input  logic [7:0]             target_address,
    input  logic [COUNT_WIDTH-1:0] first_write_count,
    input  logic [COUNT_WIDTH-1:0] second_write_count,
    input  logic [COUNT_WIDTH-1:0] read_count,
    input  logic [7:0]             write_byte,
    input  logic [15:0]            half_ticks,
    input  logic [7:0]             recovery_max,
    output i2cm_pkg::result_t      result
);

    i2cm_pkg::phase_t phase_reg, phase_next;
    logic [15:0] htc_reg, htc_next;
    logic [3:0] bitc_reg, bitc_next;
    logic [7:0] shift_reg, shift_next;
    logic [COUNT_WIDTH-1:0] fw_reg, fw_next, sw_reg, sw_next, rd_reg, rd_next;
    logic [7:0] pulses_reg, pulses_next;
    logic [6:0] addr_reg, addr_next;
    logic [7:0] hold_reg, hold_next;
    logic full_reg, full_next;
    logic scl_reg, scl_next, sda_reg, sda_next;
    logic [1:0] rstat_reg, rstat_next;
    logic reading_reg, reading_next;

    // Combinational work fields
    logic ev_valid, ev_last, ev_done;
    logic [7:0] ev_byte;
    logic [1:0] st;
    i2cm_pkg::phase_t tgt;
    logic go;
    logic [7:0] tb;
    logic take;
    logic [15:0] hsel, hcnt;
    logic [7:0] rsel, pinc;
    logic [3:0] binc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= i2cm_pkg::PH_IDLE;
            htc_reg     <= '0;
            bitc_reg    <= '0;
            shift_reg   <= '0;
            fw_reg      <= '0;
            sw_reg      <= '0;
            rd_reg      <= '0;
            pulses_reg  <= '0;
            addr_reg    <= '0;
            full_reg    <= 1'b0;
            scl_reg     <= 1'b1;
            sda_reg     <= 1'b1;
            rstat_reg   <= '0;
            reading_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            htc_reg     <= htc_next;
            bitc_reg    <= bitc_next;
            shift_reg   <= shift_next;
            fw_reg      <= fw_next;
            sw_reg      <= sw_next;
            rd_reg      <= rd_next;
            pulses_reg  <= pulses_next;
            addr_reg    <= addr_next;
            full_reg    <= full_next;
            scl_reg     <= scl_next;
            sda_reg     <= sda_next;
            rstat_reg   <= rstat_next;
            reading_reg <= reading_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            hold_reg <= hold_next;
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        htc_next     = htc_reg;
        bitc_next    = bitc_reg;
        shift_next   = shift_reg;
        fw_next      = fw_reg;
        sw_next      = sw_reg;
        rd_next      = rd_reg;
        pulses_next  = pulses_reg;
        addr_next    = addr_reg;
        hold_next    = hold_reg;
        full_next    = full_reg;
        rstat_next   = rstat_reg;
        reading_next = reading_reg;
        ev_valid = 1'b0;
        ev_last  = 1'b0;
        ev_done  = 1'b0;
        ev_byte  = '0;
        st       = i2cm_pkg::ST_OK;
        go       = 1'b0;
        tgt      = phase_reg;
        take     = 1'b0;
        tb       = write_byte;
        hsel = (half_ticks == 16'd0) ? i2cm_pkg::DEFAULT_HALF : half_ticks;
        rsel = (recovery_max == 8'd0) ? i2cm_pkg::DEFAULT_RECOVERY : recovery_max;
        hcnt = htc_reg + 16'd1;
        pinc = pulses_reg + 8'd1;
        binc = bitc_reg + 4'd1;

        case (action)
            i2cm_pkg::ACT_TICK:
            begin
                if (phase_reg != i2cm_pkg::PH_IDLE && phase_reg != i2cm_pkg::PH_WAIT_BYTE)
                begin
                    htc_next = hcnt;
                    if (hcnt >= hsel)
                    begin
                        unique case (phase_reg)
                            i2cm_pkg::PH_PROBE:
                            begin
                                pulses_next = '0;
                                go = 1'b1;
                                tgt = (sda_in && scl_in) ? i2cm_pkg::PH_START_A
                                                         : i2cm_pkg::PH_RLO;
                            end
                            i2cm_pkg::PH_RLO:
                            begin
                                go = 1'b1;
                                tgt = i2cm_pkg::PH_RHI;
                            end
                            i2cm_pkg::PH_RHI:
                            begin
                                pulses_next = pinc;
                                go = 1'b1;
                                tgt = (sda_in || pinc >= rsel) ? i2cm_pkg::PH_RSTOP_A
                                                              : i2cm_pkg::PH_RLO;
                            end
                            i2cm_pkg::PH_RSTOP_C:
                            begin
                                go = 1'b1;
                                tgt = i2cm_pkg::PH_START_A;
                            end
                            i2cm_pkg::PH_START_C:
                            begin
                                reading_next = (fw_reg == '0 && sw_reg == '0);
                                shift_next = {addr_reg, (fw_reg == '0 && sw_reg == '0)};
                                bitc_next = '0;
                                go = 1'b1;
                                tgt = i2cm_pkg::PH_WBIT_A;
                            end
                            i2cm_pkg::PH_WBIT_C:
                            begin
                                shift_next = {shift_reg[6:0], 1'b0};
                                bitc_next = binc;
                                go = 1'b1;
                                tgt = (binc >= 4'd8) ? i2cm_pkg::PH_WACK_A
                                                     : i2cm_pkg::PH_WBIT_A;
                            end
                            i2cm_pkg::PH_WACK_B:
                            begin
                                shift_next = {7'd0, sda_in};
                                go = 1'b1;
                                tgt = i2cm_pkg::PH_WACK_C;
                            end
                            i2cm_pkg::PH_WACK_C:
                            begin
                                go = 1'b1;
                                if (shift_reg[0])
                                begin
                                    rstat_next = i2cm_pkg::ST_NACK;
                                    tgt = i2cm_pkg::PH_FSTOP_A;
                                end
                                else if (reading_reg)
                                begin
                                    bitc_next = '0;
                                    shift_next = '0;
                                    tgt = (rd_reg != '0) ? i2cm_pkg::PH_RBIT_A
                                                         : i2cm_pkg::PH_FSTOP_A;
                                end
                                else if (fw_reg != '0 || sw_reg != '0)
                                begin
                                    if (full_reg)
                                    begin
                                        full_next = 1'b0;
                                        take = 1'b1;
                                        tb = hold_reg;
                                    end
                                    else
                                    begin
                                        go = 1'b0;
                                        phase_next = i2cm_pkg::PH_WAIT_BYTE;
                                    end
                                end
                                else if (rd_reg != '0)
                                begin
                                    tgt = i2cm_pkg::PH_START_A;
                                end
                                else
                                begin
                                    tgt = i2cm_pkg::PH_FSTOP_A;
                                end
                            end
                            i2cm_pkg::PH_RBIT_B:
                            begin
                                shift_next = {shift_reg[6:0], sda_in};
                                go = 1'b1;
                                tgt = i2cm_pkg::PH_RBIT_C;
                            end
                            i2cm_pkg::PH_RBIT_C:
                            begin
                                bitc_next = binc;
                                go = 1'b1;
                                if (binc < 4'd8)
                                begin
                                    tgt = i2cm_pkg::PH_RBIT_A;
                                end
                                else
                                begin
                                    ev_valid = 1'b1;
                                    ev_byte = shift_reg;
                                    ev_last = (rd_reg <= COUNT_WIDTH'(1));
                                    if (rd_reg != '0)
                                    begin
                                        rd_next = rd_reg - COUNT_WIDTH'(1);
                                    end
                                    tgt = i2cm_pkg::PH_RACK_A;
                                end
                            end
                            i2cm_pkg::PH_RACK_C:
                            begin
                                go = 1'b1;
                                if (rd_reg != '0)
                                begin
                                    bitc_next = '0;
                                    shift_next = '0;
                                    tgt = i2cm_pkg::PH_RBIT_A;
                                end
                                else
                                begin
                                    tgt = i2cm_pkg::PH_FSTOP_A;
                                end
                            end
                            i2cm_pkg::PH_FSTOP_C:
                            begin
                                phase_next = i2cm_pkg::PH_IDLE;
                                htc_next = '0;
                                full_next = 1'b0;
                                ev_done = 1'b1;
                            end
                            default:
                            begin
                                go = 1'b1;
                                tgt = i2cm_pkg::phase_t'(phase_reg + 5'd1);
                            end
                        endcase
                    end
                end
                if (ev_done)
                begin
                    st = rstat_reg;
                end
            end
            i2cm_pkg::ACT_BEGIN:
            begin
                if (phase_reg != i2cm_pkg::PH_IDLE)
                begin
                    st = i2cm_pkg::ST_REFUSED;
                end
                else if (target_address[7] || (first_write_count == '0
                         && second_write_count == '0 && read_count == '0))
                begin
                    rstat_next = i2cm_pkg::ST_INVALID;
                    full_next = 1'b0;
                    ev_done = 1'b1;
                    st = i2cm_pkg::ST_INVALID;
                end
                else
                begin
                    addr_next = target_address[6:0];
                    fw_next = first_write_count;
                    sw_next = second_write_count;
                    rd_next = read_count;
                    reading_next = 1'b0;
                    rstat_next = i2cm_pkg::ST_OK;
                    pulses_next = '0;
                    bitc_next = '0;
                    shift_next = '0;
                    go = 1'b1;
                    tgt = i2cm_pkg::PH_PROBE;
                end
            end
            i2cm_pkg::ACT_WBYTE:
            begin
                if (phase_reg == i2cm_pkg::PH_WAIT_BYTE)
                begin
                    take = 1'b1;
                end
                else
                begin
                    hold_next = write_byte;
                    full_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        // Loading a write byte: count down the active phase and start bit 7.
        if (take)
        begin
            if (fw_reg != '0)
            begin
                fw_next = fw_reg - COUNT_WIDTH'(1);
            end
            else if (sw_reg != '0)
            begin
                sw_next = sw_reg - COUNT_WIDTH'(1);
            end
            shift_next = tb;
            bitc_next = '0;
            go = 1'b1;
            tgt = i2cm_pkg::PH_WBIT_A;
        end

        // Entering a phase sets the line drive for its half period.
        scl_next = scl_reg;
        sda_next = sda_reg;
        if (go)
        begin
            phase_next = tgt;
            htc_next = '0;
            case (tgt)
                i2cm_pkg::PH_PROBE, i2cm_pkg::PH_START_A:
                begin
                    scl_next = 1'b1;
                    sda_next = 1'b1;
                end
                i2cm_pkg::PH_RLO: scl_next = 1'b0;
                i2cm_pkg::PH_RSTOP_A, i2cm_pkg::PH_FSTOP_A, i2cm_pkg::PH_START_B:
                    sda_next = 1'b0;
                i2cm_pkg::PH_RSTOP_C, i2cm_pkg::PH_FSTOP_C, i2cm_pkg::PH_WACK_A,
                i2cm_pkg::PH_RBIT_A:
                    sda_next = 1'b1;
                i2cm_pkg::PH_WBIT_A: sda_next = shift_next[7];
                i2cm_pkg::PH_RACK_A: sda_next = (rd_next == '0);
                i2cm_pkg::PH_START_C, i2cm_pkg::PH_WBIT_C, i2cm_pkg::PH_WACK_C,
                i2cm_pkg::PH_RBIT_C, i2cm_pkg::PH_RACK_C:
                    scl_next = 1'b0;
                default: scl_next = 1'b1;
            endcase
        end

        result.scl_out    = scl_next;
        result.sda_out    = sda_next;
        result.read_valid = ev_valid;
        result.read_byte  = ev_byte;
        result.read_last  = ev_valid & ev_last;
        result.need_byte  = (phase_next == i2cm_pkg::PH_WAIT_BYTE);
        result.busy_res   = (phase_next != i2cm_pkg::PH_IDLE);
        result.done_res   = ev_done;
        result.status     = st;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == i2cm_pkg::PH_IDLE) |-> (scl_reg && sda_reg))
        else $error("lines not released while idle");
    assert property (@(posedge clk) disable iff (!rst_n)
        bitc_reg <= 4'd8)
        else $error("bit counter overrun");
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && phase_reg == i2cm_pkg::PH_WAIT_BYTE && action == i2cm_pkg::ACT_TICK)
        |=> (phase_reg == i2cm_pkg::PH_WAIT_BYTE))
        else $error("left byte wait on a tick");

endmodule

>>> hdl/i2cm_out_buf.sv
// Output buffer: two-entry skid register for result transactions.
module i2cm_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  i2cm_pkg::result_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output i2cm_pkg::result_t out_data
);

    i2cm_pkg::result_t main_reg, skid_reg;
    logic main_v_reg, skid_v_reg;

    assign in_ready  = !skid_v_reg;
    assign out_valid = main_v_reg;
    assign out_data  = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_v_reg <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            if (!main_v_reg || out_ready)
            begin
                main_v_reg <= skid_v_reg || in_valid;
                skid_v_reg <= 1'b0;
            end
            else if (in_valid && in_ready)
            begin
                skid_v_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!main_v_reg || out_ready)
        begin
            main_reg <= skid_v_reg ? skid_reg : in_data;
        end
        else if (in_valid && in_ready)
        begin
            skid_reg <= in_data;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> main_v_reg)
        else $error("skid full with main empty");

endmodule

>>> hdl/i2c_master_transfer_engine.sv
// Top level: I2C master transfer engine with config registers and result buffer.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+-------------------------------------------
//  input    | in_valid / in_ready      | action, sda_in, scl_in, target_address,
//           |                          | counts, write_byte
//  result   | out_valid / out_ready    | scl_out .. status
//  config   | cfg_we (no wait)         | cfg_index, cfg_data
//
// One input transaction per clock while in_ready is high; its result is registered
// in the result buffer. The engine state machine updates in the accepting cycle.
// Reset: asynchronous, active low; lines released, engine idle, registers 5/9.
// Stalls: a two-entry result buffer keeps in_ready high until two results wait.
module i2c_master_transfer_engine #(
    parameter int COUNT_WIDTH = i2cm_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             action,
    input  logic                   sda_in,
    input  logic                   scl_in,
    input  logic [7:0]             target_address,
    input  logic [COUNT_WIDTH-1:0] first_write_count,
    input  logic [COUNT_WIDTH-1:0] second_write_count,
    input  logic [COUNT_WIDTH-1:0] read_count,
    input  logic [7:0]             write_byte,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   scl_out,
    output logic                   sda_out,
    output logic                   read_valid,
    output logic [7:0]             read_byte,
    output logic                   read_last,
    output logic                   need_byte,
    output logic                   busy_res,
    output logic                   done_res,
    output logic [1:0]             status,
    input  logic                   cfg_we,
    input  logic [0:0]             cfg_index,
    input  logic [15:0]            cfg_data
);

    logic [15:0] half_reg;
    logic [7:0] recov_reg;
    logic step;
    i2cm_pkg::result_t res, res_out;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg  <= i2cm_pkg::DEFAULT_HALF;
            recov_reg <= i2cm_pkg::DEFAULT_RECOVERY;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                i2cm_pkg::CFG_HALF:     half_reg  <= cfg_data;
                i2cm_pkg::CFG_RECOVERY: recov_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign step = in_valid && in_ready;

    i2cm_core #(.COUNT_WIDTH(COUNT_WIDTH)) u_core (
        .clk                (clk),
        .rst_n              (rst_n),
        .step               (step),
        .action             (action),
        .sda_in             (sda_in),
        .scl_in             (scl_in),
        .target_address     (target_address),
        .first_write_count  (first_write_count),
        .second_write_count (second_write_count),
        .read_count         (read_count),
        .write_byte         (write_byte),
        .half_ticks         (half_reg),
        .recovery_max       (recov_reg),
        .result             (res)
    );

    i2cm_out_buf u_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (res),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (res_out)
    );

    assign scl_out    = res_out.scl_out;
    assign sda_out    = res_out.sda_out;
    assign read_valid = res_out.read_valid;
    assign read_byte  = res_out.read_byte;
    assign read_last  = res_out.read_last;
    assign need_byte  = res_out.need_byte;
    assign busy_res   = res_out.busy_res;
    assign done_res   = res_out.done_res;
    assign status     = res_out.status;

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && read_last) |-> read_valid)
        else $error("read_last without read_valid");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && need_byte) |-> busy_res)
        else $error("byte wait while not busy");

endmodule

>>> bench/i2cm_checker.sv
// Checker: watches the engine's channels, predicts each result and compares.
module i2cm_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [1:0]        action,
    input  logic              sda_in,
    input  logic              scl_in,
    input  logic [7:0]        target_address,
    input  logic [15:0]       first_write_count,
    input  logic [15:0]       second_write_count,
    input  logic [15:0]       read_count,
    input  logic [7:0]        write_byte,
    input  logic              out_valid,
    input  logic              out_ready,
    input  i2cm_pkg::result_t actual,
    input  logic              cfg_we,
    input  logic [0:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    output int                fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [15:0]       half_reg;
    logic [7:0]        rec_reg;
    i2cm_pkg::phase_t  ph;
    logic [15:0]       tick_cnt;
    logic [3:0]        bit_cnt;
    logic [7:0]        shreg;
    logic [15:0]       w1_left, w2_left, rd_left;
    logic [7:0]        rec_pulses;
    logic [6:0]        addr_q;
    logic [7:0]        hold_byte;
    logic              hold_full;
    logic              scl_drv, sda_drv;
    logic [1:0]        xfer_status;
    logic              rd_mode;
    logic              ev_valid, ev_last, ev_done;
    logic [7:0]        ev_byte;

    i2cm_pkg::result_t expected_results[$];
    int                errors;

    assign fail_count = errors + expected_results.size();

    function automatic void goto_phase(i2cm_pkg::phase_t p);
        ph = p;
        tick_cnt = '0;
        case (p)
            i2cm_pkg::PH_PROBE, i2cm_pkg::PH_START_A:
            begin
                scl_drv = 1'b1;
                sda_drv = 1'b1;
            end
            i2cm_pkg::PH_RLO: scl_drv = 1'b0;
            i2cm_pkg::PH_RSTOP_A, i2cm_pkg::PH_FSTOP_A, i2cm_pkg::PH_START_B:
                sda_drv = 1'b0;
            i2cm_pkg::PH_RSTOP_C, i2cm_pkg::PH_FSTOP_C, i2cm_pkg::PH_WACK_A,
            i2cm_pkg::PH_RBIT_A:
                sda_drv = 1'b1;
            i2cm_pkg::PH_WBIT_A: sda_drv = shreg[7];
            i2cm_pkg::PH_RACK_A: sda_drv = (rd_left == 0);
            i2cm_pkg::PH_START_C, i2cm_pkg::PH_WBIT_C, i2cm_pkg::PH_WACK_C,
            i2cm_pkg::PH_RBIT_C, i2cm_pkg::PH_RACK_C:
                scl_drv = 1'b0;
            default: scl_drv = 1'b1;
        endcase
    endfunction

    function automatic void load_byte(logic [7:0] b);
        if (w1_left != 0) w1_left--;
        else if (w2_left != 0) w2_left--;
        shreg = b;
        bit_cnt = '0;
        goto_phase(i2cm_pkg::PH_WBIT_A);
    endfunction

    function automatic void ack_done();
        if (shreg[0]) begin
            xfer_status = i2cm_pkg::ST_NACK;
            goto_phase(i2cm_pkg::PH_FSTOP_A);
        end else if (rd_mode) begin
            bit_cnt = '0;
            shreg = '0;
            goto_phase(rd_left != 0 ? i2cm_pkg::PH_RBIT_A : i2cm_pkg::PH_FSTOP_A);
        end else if (w1_left != 0 || w2_left != 0) begin
            if (hold_full) begin
                hold_full = 1'b0;
                load_byte(hold_byte);
            end else begin
                ph = i2cm_pkg::PH_WAIT_BYTE;
            end
        end else if (rd_left != 0) begin
            goto_phase(i2cm_pkg::PH_START_A);
        end else begin
            goto_phase(i2cm_pkg::PH_FSTOP_A);
        end
    endfunction

    function automatic void half_period_end(logic sda, logic scl);
        logic [7:0] lim;
        lim = (rec_reg == 0) ? i2cm_pkg::DEFAULT_RECOVERY : rec_reg;
        case (ph)
            i2cm_pkg::PH_PROBE: begin
                rec_pulses = '0;
                goto_phase((sda && scl) ? i2cm_pkg::PH_START_A : i2cm_pkg::PH_RLO);
            end
            i2cm_pkg::PH_RLO: goto_phase(i2cm_pkg::PH_RHI);
            i2cm_pkg::PH_RHI: begin
                rec_pulses++;
                goto_phase((sda || rec_pulses >= lim) ? i2cm_pkg::PH_RSTOP_A
                                                      : i2cm_pkg::PH_RLO);
            end
            i2cm_pkg::PH_RSTOP_C: goto_phase(i2cm_pkg::PH_START_A);
            i2cm_pkg::PH_START_C: begin
                rd_mode = (w1_left == 0 && w2_left == 0);
                shreg = {addr_q, rd_mode};
                bit_cnt = '0;
                goto_phase(i2cm_pkg::PH_WBIT_A);
            end
            i2cm_pkg::PH_WBIT_C: begin
                shreg = shreg << 1;
                bit_cnt++;
                goto_phase(bit_cnt >= 8 ? i2cm_pkg::PH_WACK_A : i2cm_pkg::PH_WBIT_A);
            end
            i2cm_pkg::PH_WACK_B: begin
                shreg = {7'd0, sda};
                goto_phase(i2cm_pkg::PH_WACK_C);
            end
            i2cm_pkg::PH_WACK_C: ack_done();
            i2cm_pkg::PH_RBIT_B: begin
                shreg = {shreg[6:0], sda};
                goto_phase(i2cm_pkg::PH_RBIT_C);
            end
            i2cm_pkg::PH_RBIT_C: begin
                bit_cnt++;
                if (bit_cnt < 8) begin
                    goto_phase(i2cm_pkg::PH_RBIT_A);
                end else begin
                    ev_valid = 1'b1;
                    ev_byte = shreg;
                    ev_last = (rd_left <= 1);
                    if (rd_left != 0) rd_left--;
                    goto_phase(i2cm_pkg::PH_RACK_A);
                end
            end
            i2cm_pkg::PH_RACK_C: begin
                if (rd_left != 0) begin
                    bit_cnt = '0;
                    shreg = '0;
                    goto_phase(i2cm_pkg::PH_RBIT_A);
                end else begin
                    goto_phase(i2cm_pkg::PH_FSTOP_A);
                end
            end
            i2cm_pkg::PH_FSTOP_C: begin
                ph = i2cm_pkg::PH_IDLE;
                tick_cnt = '0;
                hold_full = 1'b0;
                ev_done = 1'b1;
            end
            default: goto_phase(i2cm_pkg::phase_t'(ph + 1));
        endcase
    endfunction

    function automatic i2cm_pkg::result_t predict_bus_step();
        i2cm_pkg::result_t r;
        logic [1:0]  st;
        logic [15:0] h;
        st = i2cm_pkg::ST_OK;
        ev_valid = 1'b0;
        ev_last = 1'b0;
        ev_done = 1'b0;
        ev_byte = '0;
        case (i2cm_pkg::action_t'(action))
            i2cm_pkg::ACT_TICK: begin
                if (ph != i2cm_pkg::PH_IDLE && ph != i2cm_pkg::PH_WAIT_BYTE) begin
                    h = (half_reg == 0) ? i2cm_pkg::DEFAULT_HALF : half_reg;
                    tick_cnt++;
                    if (tick_cnt >= h) half_period_end(sda_in, scl_in);
                end
                if (ev_done) st = xfer_status;
            end
            i2cm_pkg::ACT_BEGIN: begin
                if (ph != i2cm_pkg::PH_IDLE) begin
                    st = i2cm_pkg::ST_REFUSED;
                end else if (target_address >= 8'h80 || (first_write_count == 0
                         && second_write_count == 0 && read_count == 0)) begin
                    xfer_status = i2cm_pkg::ST_INVALID;
                    hold_full = 1'b0;
                    ev_done = 1'b1;
                    st = i2cm_pkg::ST_INVALID;
                end else begin
                    addr_q = target_address[6:0];
                    w1_left = first_write_count;
                    w2_left = second_write_count;
                    rd_left = read_count;
                    rd_mode = 1'b0;
                    xfer_status = i2cm_pkg::ST_OK;
                    rec_pulses = '0;
                    bit_cnt = '0;
                    shreg = '0;
                    goto_phase(i2cm_pkg::PH_PROBE);
                end
            end
            i2cm_pkg::ACT_WBYTE: begin
                if (ph == i2cm_pkg::PH_WAIT_BYTE) load_byte(write_byte);
                else begin hold_byte = write_byte; hold_full = 1'b1; end
            end
            default: ;
        endcase
        r.scl_out = scl_drv;
        r.sda_out = sda_drv;
        r.read_valid = ev_valid;
        r.read_byte = ev_valid ? ev_byte : 8'd0;
        r.read_last = ev_valid && ev_last;
        r.need_byte = (ph == i2cm_pkg::PH_WAIT_BYTE);
        r.busy_res = (ph != i2cm_pkg::PH_IDLE);
        r.done_res = ev_done;
        r.status = st;
        return r;
    endfunction

    function automatic void check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        i2cm_pkg::result_t e;
        if (!rst_n) begin
            half_reg = i2cm_pkg::DEFAULT_HALF;
            rec_reg = i2cm_pkg::DEFAULT_RECOVERY;
            ph = i2cm_pkg::PH_IDLE;
            tick_cnt = '0;
            bit_cnt = '0;
            shreg = '0;
            w1_left = '0;
            w2_left = '0;
            rd_left = '0;
            rec_pulses = '0;
            addr_q = '0;
            hold_byte = '0;
            hold_full = 1'b0;
            scl_drv = 1'b1;
            sda_drv = 1'b1;
            xfer_status = i2cm_pkg::ST_OK;
            rd_mode = 1'b0;
            errors = 0;
            expected_results.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == i2cm_pkg::CFG_HALF) half_reg = cfg_data;
                else rec_reg = cfg_data[7:0];
            end
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result transaction, expected none, actual %h",
                             $time, actual);
                    errors++;
                end else begin
                    e = expected_results.pop_front();
                    check_field("scl_out", e.scl_out, actual.scl_out);
                    check_field("sda_out", e.sda_out, actual.sda_out);
                    check_field("read_valid", e.read_valid, actual.read_valid);
                    check_field("read_byte", e.read_byte, actual.read_byte);
                    check_field("read_last", e.read_last, actual.read_last);
                    check_field("need_byte", e.need_byte, actual.need_byte);
                    check_field("busy_res", e.busy_res, actual.busy_res);
                    check_field("done_res", e.done_res, actual.done_res);
                    check_field("status", e.status, actual.status);
                end
            end
            if (in_valid && in_ready) expected_results.push_back(predict_bus_step());
        end
    end

endmodule

>>> bench/tb.sv
// Testbench top: stimulus for the I2C master engine and the final verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [1:0]        action = i2cm_pkg::ACT_NOP;
    logic              sda_in = 1'b1;
    logic              scl_in = 1'b1;
    logic [7:0]        target_address = '0;
    logic [15:0]       first_write_count = '0;
    logic [15:0]       second_write_count = '0;
    logic [15:0]       read_count = '0;
    logic [7:0]        write_byte = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    i2cm_pkg::result_t res;
    logic              cfg_we = 1'b0;
    logic [0:0]        cfg_index = i2cm_pkg::CFG_HALF;
    logic [15:0]       cfg_data = '0;
    int                fail_count;

    // transaction counts on both channels, and the latest observed engine flags
    int   sent_cnt = 0;
    int   recv_cnt = 0;
    logic last_busy = 1'b0;
    logic last_need = 1'b0;
    // calm: no idling on either side
    logic calm = 1'b0;

    always #4 clk = ~clk;

    i2c_master_transfer_engine i_dut (
        .clk, .rst_n, .in_valid, .in_ready, .action, .sda_in, .scl_in,
        .target_address, .first_write_count, .second_write_count, .read_count,
        .write_byte, .out_valid, .out_ready,
        .scl_out(res.scl_out), .sda_out(res.sda_out), .read_valid(res.read_valid),
        .read_byte(res.read_byte), .read_last(res.read_last), .need_byte(res.need_byte),
        .busy_res(res.busy_res), .done_res(res.done_res), .status(res.status),
        .cfg_we, .cfg_index, .cfg_data
    );

    i2cm_checker i_checker (
        .clk, .rst_n, .in_valid, .in_ready, .action, .sda_in, .scl_in,
        .target_address, .first_write_count, .second_write_count, .read_count,
        .write_byte, .out_valid, .out_ready, .actual(res),
        .cfg_we, .cfg_index, .cfg_data, .fail_count
    );

    // Result side: stalls about one cycle in five unless calm.
    always @(posedge clk) begin
        out_ready <= calm || ($urandom_range(99) >= 20);
        if (out_valid && out_ready) begin
            recv_cnt  <= recv_cnt + 1;
            last_busy <= res.busy_res;
            last_need <= res.need_byte;
        end
    end

    // Timeout guard.
    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    // One input transaction; valid stays up afterwards until dropped or reused.
    task automatic send_cmd(logic [1:0] act, logic sda, logic scl, logic [7:0] addr,
                            logic [15:0] c1, logic [15:0] c2, logic [15:0] c3,
                            logic [7:0] wb);
        if (!calm && $urandom_range(99) < 10) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid           <= 1'b1;
        action             <= act;
        sda_in             <= sda;
        scl_in             <= scl;
        target_address     <= addr;
        first_write_count  <= c1;
        second_write_count <= c2;
        read_count         <= c3;
        write_byte         <= wb;
        do @(posedge clk); while (!in_ready);
        sent_cnt++;
    endtask

    task automatic wait_results();
        in_valid <= 1'b0;
        while (recv_cnt != sent_cnt) @(posedge clk);
    endtask

    // Bring the engine back to idle: SDA high makes every write ACK slot a NACK,
    // ends recovery, and a stop follows; stalls get fed a byte.
    task automatic drain_to_idle();
        wait_results();
        while (last_busy) begin
            if (last_need) send_cmd(i2cm_pkg::ACT_WBYTE, 1'b1, 1'b1, 8'd0, 16'd0, 16'd0,
                                    16'd0, 8'($urandom));
            else send_cmd(i2cm_pkg::ACT_TICK, 1'b1, 1'b1, 8'd0, 16'd0, 16'd0, 16'd0, 8'd0);
            wait_results();
        end
    endtask

    task automatic write_reg(logic [0:0] idx, logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Mostly ticks with ACK-friendly SDA; short transfers, occasional huge
    // write counts (aborted by NACK) and rejected begins with any counts.
    task automatic random_traffic(int n);
        int          pick;
        logic [7:0]  addr;
        logic [15:0] c1, c2, c3;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(99);
            if (pick < 4) begin
                addr = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(127));
                c1 = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(2));
                c2 = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(2));
                c3 = (addr >= 8'h80) ? 16'($urandom) : 16'($urandom_range(3));
                send_cmd(i2cm_pkg::ACT_BEGIN, 1'($urandom), 1'($urandom), addr, c1, c2, c3,
                         8'($urandom));
            end else if (pick < 14) begin
                send_cmd(i2cm_pkg::ACT_WBYTE, 1'($urandom), 1'($urandom), 8'($urandom),
                         16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
            end else if (pick < 16) begin
                send_cmd(i2cm_pkg::ACT_NOP, 1'($urandom), 1'($urandom), 8'($urandom),
                         16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
            end else begin
                send_cmd(i2cm_pkg::ACT_TICK, $urandom_range(99) < 35,
                         $urandom_range(99) < 85, 8'($urandom), 16'($urandom),
                         16'($urandom), 16'($urandom), 8'($urandom));
            end
        end
        drain_to_idle();
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at short half periods.
        write_reg(i2cm_pkg::CFG_HALF, 16'd1);
        write_reg(i2cm_pkg::CFG_RECOVERY, 16'd2);
        send_cmd(i2cm_pkg::ACT_BEGIN, 1'b0, 1'b0, 8'h80, 16'd1, 16'd0, 16'd0, 8'h00);
        send_cmd(i2cm_pkg::ACT_BEGIN, 1'b1, 1'b1, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                 8'hFF);
        send_cmd(i2cm_pkg::ACT_BEGIN, 1'b0, 1'b1, 8'h05, 16'd0, 16'd0, 16'd0, 8'h00);
        send_cmd(i2cm_pkg::ACT_NOP, 1'b1, 1'b0, 8'h7F, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
        send_cmd(i2cm_pkg::ACT_TICK, 1'b0, 1'b0, 8'h00, 16'd0, 16'd0, 16'd0, 8'h00);
        // early byte loads, the second overwrites the first
        send_cmd(i2cm_pkg::ACT_WBYTE, 1'b0, 1'b0, 8'h00, 16'd0, 16'd0, 16'd0, 8'hFF);
        send_cmd(i2cm_pkg::ACT_WBYTE, 1'b0, 1'b0, 8'h00, 16'd0, 16'd0, 16'd0, 8'hA5);
        send_cmd(i2cm_pkg::ACT_BEGIN, 1'b0, 1'b0, 8'h7F, 16'd1, 16'd1, 16'd2, 8'h00);
        // begin while busy is refused
        send_cmd(i2cm_pkg::ACT_BEGIN, 1'b0, 1'b0, 8'h00, 16'd1, 16'd0, 16'd0, 8'h00);
        // idle bus at probe, then ACKs from the target
        send_cmd(i2cm_pkg::ACT_TICK, 1'b1, 1'b1, 8'h00, 16'd0, 16'd0, 16'd0, 8'h00);
        for (int k = 0; k < 10; k++)
            send_cmd(i2cm_pkg::ACT_TICK, 1'b0, 1'b1, 8'h00, 16'd0, 16'd0, 16'd0, 8'h00);
        drain_to_idle();
        // read-only transfer through a stuck bus and recovery
        send_cmd(i2cm_pkg::ACT_BEGIN, 1'b0, 1'b0, 8'h00, 16'd0, 16'd0, 16'd1, 8'h00);
        for (int k = 0; k < 8; k++)
            send_cmd(i2cm_pkg::ACT_TICK, 1'b0, 1'b0, 8'h00, 16'd0, 16'd0, 16'd0, 8'h00);
        drain_to_idle();

        random_traffic(600);
        write_reg(i2cm_pkg::CFG_HALF, 16'd0);
        write_reg(i2cm_pkg::CFG_RECOVERY, 16'd0);
        random_traffic(500);
        calm = 1'b1;
        write_reg(i2cm_pkg::CFG_HALF, 16'd2);
        write_reg(i2cm_pkg::CFG_RECOVERY, 16'd255);
        random_traffic(500);
        calm = 1'b0;
        write_reg(i2cm_pkg::CFG_HALF, 16'd1);
        write_reg(i2cm_pkg::CFG_RECOVERY, 16'd1);
        random_traffic(500);

        // Longest half period: only idle and rejected traffic fits in the run.
        write_reg(i2cm_pkg::CFG_HALF, 16'hFFFF);
        send_cmd(i2cm_pkg::ACT_BEGIN, 1'b1, 1'b1, 8'hC3, 16'h1234, 16'd0, 16'd9, 8'h00);
        send_cmd(i2cm_pkg::ACT_TICK, 1'b1, 1'b1, 8'h00, 16'd0, 16'd0, 16'd0, 8'h00);
        send_cmd(i2cm_pkg::ACT_WBYTE, 1'b1, 1'b1, 8'h00, 16'd0, 16'd0, 16'd0, 8'h3C);
        drain_to_idle();
        write_reg(i2cm_pkg::CFG_HALF, 16'd3);
        write_reg(i2cm_pkg::CFG_RECOVERY, 16'd9);
        random_traffic(300);

        wait_results();
        repeat (5) @(posedge clk);
        if (fail_count == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

endmodule

>>> sim.f
hdl/i2cm_pkg.sv
hdl/i2cm_core.sv
hdl/i2cm_out_buf.sv
hdl/i2c_master_transfer_engine.sv
bench/i2cm_checker.sv
bench/tb.sv
